FILE: hdl/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

	localparam int RING_DEPTH = 8;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int PERIOD_W   = 16;
	localparam int SUM_W      = PERIOD_W + RING_AW;
	localparam int MHZ_W      = 8;
	localparam int PRE_W      = 11;
	localparam int CFG_W      = 11;
	localparam int RPM_W      = 8;
	localparam int DIV_W      = PERIOD_W + PRE_W;
	localparam int CNT_W      = $clog2(DIV_W);
	localparam int HZ_W       = 13;
	localparam int RECIP_W    = 22;
	localparam int SCALE_W    = HZ_W + RECIP_W;

	// microseconds per second
	localparam logic [DIV_W-1:0]   USEC_PER_SEC = DIV_W'(1000000);
	// smallest hz giving hz*60/1000 above 255
	localparam logic [DIV_W-1:0]   HZ_SAT       = DIV_W'(4267);
	// ceil(2^26 * 60 / 1000): hz*60/1000 as multiply and shift
	localparam logic [RECIP_W-1:0] RECIP        = RECIP_W'(4026532);
	localparam int                 RECIP_SH     = 26;
	localparam logic [RPM_W-1:0]   RPM_MAX      = '1;

	localparam logic MODE_CAPTURE = 1'b0;
	localparam logic MODE_TIMEOUT = 1'b1;

	localparam logic REG_CPU_MHZ  = 1'b0;
	localparam logic REG_PRESCALE = 1'b1;

	localparam logic [MHZ_W-1:0] CPU_MHZ_RST  = MHZ_W'(16);
	localparam logic [PRE_W-1:0] PRESCALE_RST = PRE_W'(256);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_WAIT_US,
		ST_WAIT_HZ,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		RPM_ZERO,
		RPM_SAT,
		RPM_CALC
	} rpm_src_t;

	typedef enum logic {
		DIV_US,
		DIV_HZ
	} div_sel_t;

	typedef struct packed {
		logic     accept;
		logic     mul_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     scale_load;
		logic     out_load;
		rpm_src_t rpm_src;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mean_zero;
		logic cpu_zero;
		logic div_done;
		logic us_zero;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/tpr_div.sv
`default_nettype none

module tpr_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire  [tpr_pkg::DIV_W-1:0] dividend,
	input  wire  [tpr_pkg::DIV_W-1:0] divisor,
	output logic [tpr_pkg::DIV_W-1:0] quotient,
	output logic                      done
);
	import tpr_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

FILE: hdl/tpr_datapath.sv
`default_nettype none

module tpr_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire                          cfg_index,
	input  wire  [tpr_pkg::CFG_W-1:0]    cfg_data,
	input  wire                          mode,
	input  wire  [tpr_pkg::PERIOD_W-1:0] period_ticks,
	input  tpr_pkg::ctrl_cmd_t           cmd,
	output tpr_pkg::dp_status_t          status,
	output logic [tpr_pkg::PERIOD_W-1:0] avg_ticks,
	output logic [tpr_pkg::RPM_W-1:0]    rpm_thousands
);
	import tpr_pkg::*;

	logic [MHZ_W-1:0]    cpu_mhz_q;
	logic [PRE_W-1:0]    prescale_q;
	logic [PERIOD_W-1:0] ring_q [RING_DEPTH];
	logic [RING_AW-1:0]  slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PERIOD_W-1:0] mean;
	logic [DIV_W-1:0]    prod_q;
	logic [DIV_W-1:0]    dividend;
	logic [DIV_W-1:0]    divisor;
	logic [DIV_W-1:0]    quotient;
	logic                div_done;
	logic [SCALE_W-1:0]  scale_q;
	logic                hz_big_q;
	logic [RPM_W-1:0]    rpm;
	logic [PERIOD_W-1:0] avg_q;
	logic [RPM_W-1:0]    rpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_mhz_q  <= CPU_MHZ_RST;
			prescale_q <= PRESCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CPU_MHZ:  cpu_mhz_q  <= cfg_data[MHZ_W-1:0];
				REG_PRESCALE: prescale_q <= cfg_data[PRE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
			slot_q <= '0;
			sum_q  <= '0;
		end else if (cmd.accept) begin
			if (mode == MODE_TIMEOUT) begin
				for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
				sum_q <= '0;
			end else begin
				ring_q[slot_q] <= period_ticks;
				sum_q  <= sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(period_ticks);
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign mean = sum_q[SUM_W-1:RING_AW];

	always_ff @(posedge clk) begin
		if (cmd.mul_load) prod_q <= DIV_W'(mean) * DIV_W'(prescale_q);
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_US: begin
				dividend = prod_q;
				divisor  = DIV_W'(cpu_mhz_q);
			end
			DIV_HZ: begin
				dividend = USEC_PER_SEC;
				divisor  = quotient;
			end
			default: begin
				dividend = prod_q;
				divisor  = DIV_W'(cpu_mhz_q);
			end
		endcase
	end

	tpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.scale_load) begin
			hz_big_q <= (quotient >= HZ_SAT);
			scale_q  <= SCALE_W'(quotient[HZ_W-1:0]) * SCALE_W'(RECIP);
		end
	end

	always_comb begin
		case (cmd.rpm_src)
			RPM_ZERO: rpm = '0;
			RPM_SAT:  rpm = RPM_MAX;
			RPM_CALC: rpm = hz_big_q ? RPM_MAX : scale_q[RECIP_SH+RPM_W-1:RECIP_SH];
			default:  rpm = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_q <= mean;
			rpm_q <= rpm;
		end
	end

	assign status.mean_zero = (mean == '0);
	assign status.cpu_zero  = (cpu_mhz_q == '0);
	assign status.div_done  = div_done;
	assign status.us_zero   = (quotient == '0);

	assign avg_ticks     = avg_q;
	assign rpm_thousands = rpm_q;

endmodule

`default_nettype wire

FILE: hdl/tpr_ctrl.sv
`default_nettype none

module tpr_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  tpr_pkg::dp_status_t   status,
	output tpr_pkg::ctrl_cmd_t    cmd
);
	import tpr_pkg::*;

	state_t   state_q, state_d;
	rpm_src_t src_q, src_d;
	logic     out_valid_q, out_valid_d;
	logic     out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			src_q       <= RPM_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			src_q       <= src_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		src_d          = src_q;
		out_valid_d    = out_valid_q && !out_ready;
		in_ready       = 1'b0;
		cmd.accept     = 1'b0;
		cmd.mul_load   = 1'b0;
		cmd.div_start  = 1'b0;
		cmd.div_sel    = DIV_US;
		cmd.scale_load = 1'b0;
		cmd.out_load   = 1'b0;
		cmd.rpm_src    = src_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.mean_zero) begin
					src_d   = RPM_ZERO;
					state_d = ST_OUT;
				end else if (status.cpu_zero) begin
					src_d   = RPM_SAT;
					state_d = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_WAIT_US;
				end
			end
			ST_WAIT_US: begin
				if (status.div_done) begin
					if (status.us_zero) begin
						src_d   = RPM_SAT;
						state_d = ST_OUT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_HZ;
						state_d       = ST_WAIT_HZ;
					end
				end
			end
			ST_WAIT_HZ: begin
				cmd.div_sel = DIV_HZ;
				if (status.div_done) begin
					cmd.scale_load = 1'b1;
					src_d          = RPM_CALC;
					state_d        = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/tach_period_average_rpm.sv
`default_nettype none

// Tachometer period averager. Each input transaction is a captured edge period
// (tuser 0) or a capture-timer overflow timeout (tuser 1, ring cleared). Every
// transaction yields one output: the mean of the last eight periods and the
// speed in thousands of rpm, from us = mean*prescale/cpu_mhz, hz = 1e6/us,
// rpm = hz*60/1000, zero for a zero mean and saturating at 255. One shared
// one-bit-per-cycle divider (27 steps) serves both divisions, which are skipped
// when the mean or cpu_mhz is zero. A finished result sits in the output
// register while the next transaction is taken. cpu_mhz is register 0,
// prescale_div register 1.
module tach_period_average_rpm (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [10:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // period_ticks
	input  wire         s_tuser,   // mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // avg_ticks[15:0], rpm_thousands[23:16]
);
	import tpr_pkg::*;

	ctrl_cmd_t           cmd;
	dp_status_t          status;
	logic [PERIOD_W-1:0] avg_ticks;
	logic [RPM_W-1:0]    rpm_thousands;

	tpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	tpr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (s_tuser),
		.period_ticks  (s_tdata),
		.cmd           (cmd),
		.status        (status),
		.avg_ticks     (avg_ticks),
		.rpm_thousands (rpm_thousands)
	);

	assign m_tdata = {rpm_thousands, avg_ticks};

endmodule

`default_nettype wire
